// ----- rtl/core/cqv_pkg.sv -----
// ----------------------------------------------------------------------------
// cqv_pkg: shared types and constants of the crossed quad vertex generator
// Widths of the coordinate words, the configuration register map and the
// first-quadrant cosine and sine tables in unsigned Q0.15.
// ----------------------------------------------------------------------------
package cqv_pkg;

    localparam int MAX_DIVISIONS = 16;
    localparam int DIV_W         = $clog2(MAX_DIVISIONS);
    localparam int QK_N          = MAX_DIVISIONS / 2 + 1;
    localparam int KR_W          = $clog2(QK_N);

    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = 31;
    localparam int DIVREG_W   = 5;
    localparam int TRIG_W     = 15;
    localparam int PROD_W     = RADIUS_W + TRIG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [TRIG_W-1:0] t_trig;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS    = 3'd0,
        CFG_HEIGHT    = 3'd1,
        CFG_DIVISIONS = 3'd2,
        CFG_TEX_LEFT  = 3'd3,
        CFG_TEX_RIGHT = 3'd4
    } t_cfg_idx;

    // Row n-1, column k holds round(32768*cos(k*pi/n)) for k up to n/2,
    // limited to 32767. Later quads are mirrored from these entries.
    localparam t_trig COS_Q1 [MAX_DIVISIONS][QK_N] = '{
        '{15'd32767, 15'd0,     15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd0,     15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd16384, 15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd23170, 15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd26510, 15'd10126, 15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd28378, 15'd16384, 15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd29523, 15'd20431, 15'd7292,  15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd30274, 15'd23170, 15'd12540, 15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd30792, 15'd25102, 15'd16384, 15'd5690,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd31164, 15'd26510, 15'd19261, 15'd10126,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd31441, 15'd27566, 15'd21458, 15'd13612,
          15'd4663,  15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd31651, 15'd28378, 15'd23170, 15'd16384,
          15'd8481,  15'd0,     15'd0,     15'd0},
        '{15'd32767, 15'd31816, 15'd29015, 15'd24527, 15'd18614,
          15'd11620, 15'd3950,  15'd0,     15'd0},
        '{15'd32767, 15'd31946, 15'd29523, 15'd25619, 15'd20431,
          15'd14218, 15'd7292,  15'd0,     15'd0},
        '{15'd32767, 15'd32052, 15'd29935, 15'd26510, 15'd21926,
          15'd16384, 15'd10126, 15'd3425,  15'd0},
        '{15'd32767, 15'd32138, 15'd30274, 15'd27246, 15'd23170,
          15'd18205, 15'd12540, 15'd6393,  15'd0}
    };

    localparam t_trig SIN_Q1 [MAX_DIVISIONS][QK_N] = '{
        '{15'd0,     15'd0,     15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd32767, 15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd28378, 15'd0,     15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd23170, 15'd32767, 15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd19261, 15'd31164, 15'd0,     15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd16384, 15'd28378, 15'd32767, 15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd14218, 15'd25619, 15'd31946, 15'd0,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd12540, 15'd23170, 15'd30274, 15'd32767,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd11207, 15'd21063, 15'd28378, 15'd32270,
          15'd0,     15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd10126, 15'd19261, 15'd26510, 15'd31164,
          15'd32767, 15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd9232,  15'd17716, 15'd24764, 15'd29807,
          15'd32434, 15'd0,     15'd0,     15'd0},
        '{15'd0,     15'd8481,  15'd16384, 15'd23170, 15'd28378,
          15'd31651, 15'd32767, 15'd0,     15'd0},
        '{15'd0,     15'd7842,  15'd15228, 15'd21729, 15'd26968,
          15'd30639, 15'd32529, 15'd0,     15'd0},
        '{15'd0,     15'd7292,  15'd14218, 15'd20431, 15'd25619,
          15'd29523, 15'd31946, 15'd32767, 15'd0},
        '{15'd0,     15'd6813,  15'd13328, 15'd19261, 15'd24351,
          15'd28378, 15'd31164, 15'd32588, 15'd0},
        '{15'd0,     15'd6393,  15'd12540, 15'd18205, 15'd23170,
          15'd27246, 15'd30274, 15'd32138, 15'd32767}
    };

endpackage

// ----- rtl/core/cqv_in_if.sv -----
// ----------------------------------------------------------------------------
// cqv_in_if: base position channel
// Valid/ready channel that carries one base position per word.
// ----------------------------------------------------------------------------
interface cqv_in_if import cqv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [COORD_W-1:0] base_z;

    modport source (output valid, output base_x, output base_y, output base_z,
                    input ready);
    modport sink   (input valid, input base_x, input base_y, input base_z,
                    output ready);
endinterface

// ----- rtl/core/cqv_out_if.sv -----
// ----------------------------------------------------------------------------
// cqv_out_if: vertex channel
// Valid/ready channel that carries one vertex per word.
// ----------------------------------------------------------------------------
interface cqv_out_if import cqv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] vert_x;
    logic [COORD_W-1:0] vert_y;
    logic [COORD_W-1:0] vert_z;
    logic [COORD_W-1:0] tex_u;
    logic               tex_v_bottom;
    logic               last_vertex;

    modport source (output valid, output vert_x, output vert_y, output vert_z,
                    output tex_u, output tex_v_bottom, output last_vertex,
                    input ready);
    modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                    input tex_u, input tex_v_bottom, input last_vertex,
                    output ready);
endinterface

// ----- rtl/core/crossed_quad_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// crossed_quad_vertex_generator: crossed quad billboard vertex expander
// Each base position word is expanded into 4*n vertices (n quads rotated
// about the vertical axis), one vertex word per cycle through a 4-stage pipe.
// ----------------------------------------------------------------------------
// A position with n effective divisions (divisions clamped to 1..16) yields
// 4*n vertex words, top-left, top-right, bottom-left, bottom-right per quad,
// and last_vertex marks the final one. The vertex sequencer issues one vertex
// per cycle while the output is not stalled; the next position is taken in the
// cycle its predecessor issues its last vertex, so vertex words leave back to
// back. A vertex passes from its issue through the table lookup, multiply,
// add and saturate, and output register stages on its way to the output. A
// stalled output freezes the whole pipe. Configuration must only be written
// while no position is in flight.
module crossed_quad_vertex_generator import cqv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cqv_in_if.sink                i_vin,
    cqv_out_if.source             o_vout
);

    function automatic logic [COORD_W-1:0] sat34(input logic signed [COORD_W+1:0] v);
        logic [COORD_W-1:0] res;
        if (v > $signed({2'b00, 1'b0, {(COORD_W-1){1'b1}}})) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < $signed({2'b11, 1'b1, {(COORD_W-1){1'b0}}})) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic [RADIUS_W-1:0] r_radius;
    logic [COORD_W-1:0]  r_height;
    logic [DIVREG_W-1:0] r_divisions;
    logic [COORD_W-1:0]  r_tex_left;
    logic [COORD_W-1:0]  r_tex_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_W'(65536);
            r_height    <= COORD_W'(65536);
            r_divisions <= DIVREG_W'(1);
            r_tex_left  <= '0;
            r_tex_right <= COORD_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:    r_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data;
                CFG_DIVISIONS: r_divisions <= i_cfg_data[DIVREG_W-1:0];
                CFG_TEX_LEFT:  r_tex_left  <= i_cfg_data;
                CFG_TEX_RIGHT: r_tex_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective division count minus one.
    logic [DIV_W-1:0]    nm1;
    logic [DIVREG_W-1:0] div_m1;

    always_comb begin
        div_m1 = r_divisions - DIVREG_W'(1);
        if (r_divisions == '0) begin
            nm1 = '0;
        end else if (r_divisions > DIVREG_W'(MAX_DIVISIONS)) begin
            nm1 = DIV_W'(MAX_DIVISIONS - 1);
        end else begin
            nm1 = div_m1[DIV_W-1:0];
        end
    end

    // Vertex sequencer
    logic               r_cur_vld;
    logic [DIV_W-1:0]   r_k;
    logic [1:0]         r_v;
    logic [COORD_W-1:0] r_cur_x;
    logic [COORD_W-1:0] r_cur_y;
    logic [COORD_W-1:0] r_cur_z;

    logic adv;
    logic issue;
    logic is_last;
    logic in_acc;

    assign adv     = !o_vout.valid || o_vout.ready;
    assign issue   = adv && r_cur_vld;
    assign is_last = (r_k == nm1) && (r_v == 2'd3);
    assign i_vin.ready = !r_cur_vld || (issue && is_last);
    assign in_acc  = i_vin.valid && i_vin.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_k       <= '0;
            r_v       <= '0;
        end else if (in_acc) begin
            r_cur_vld <= 1'b1;
            r_k       <= '0;
            r_v       <= '0;
        end else if (issue) begin
            if (is_last) begin
                r_cur_vld <= 1'b0;
            end else begin
                r_v <= r_v + 2'd1;
                if (r_v == 2'd3) begin
                    r_k <= r_k + DIV_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur_x <= i_vin.base_x;
            r_cur_y <= i_vin.base_y;
            r_cur_z <= i_vin.base_z;
        end
    end

    // Stage 1: quad index registered, table lookup in front of stage 2.
    logic               r_s1_vld;
    logic [DIV_W-1:0]   r_s1_k;
    logic [1:0]         r_s1_v;
    logic               r_s1_last;
    logic [COORD_W-1:0] r_s1_x;
    logic [COORD_W-1:0] r_s1_y;
    logic [COORD_W-1:0] r_s1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= r_cur_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_k    <= r_k;
            r_s1_v    <= r_v;
            r_s1_last <= is_last;
            r_s1_x    <= r_cur_x;
            r_s1_y    <= r_cur_y;
            r_s1_z    <= r_cur_z;
        end
    end

    // Quads past the quarter turn mirror the first quadrant: the sine repeats
    // and the cosine changes sign.
    logic [DIV_W:0]  n_cnt;
    logic            refl;
    logic [DIV_W:0]  kr_full;
    logic [KR_W-1:0] kr;
    t_trig           n_s2_cos;
    t_trig           n_s2_sin;

    always_comb begin
        n_cnt    = {1'b0, nm1} + (DIV_W+1)'(1);
        refl     = {r_s1_k, 1'b0} > n_cnt;
        kr_full  = refl ? (n_cnt - {1'b0, r_s1_k}) : {1'b0, r_s1_k};
        kr       = kr_full[KR_W-1:0];
        n_s2_cos = COS_Q1[nm1][kr];
        n_s2_sin = SIN_Q1[nm1][kr];
    end

    // Stage 2: trig magnitudes registered, multiply by the radius.
    logic               r_s2_vld;
    t_trig              r_s2_cos;
    t_trig              r_s2_sin;
    logic               r_s2_neg;
    logic [1:0]         r_s2_v;
    logic               r_s2_last;
    logic [COORD_W-1:0] r_s2_x;
    logic [COORD_W-1:0] r_s2_y;
    logic [COORD_W-1:0] r_s2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_cos  <= n_s2_cos;
            r_s2_sin  <= n_s2_sin;
            r_s2_neg  <= refl;
            r_s2_v    <= r_s1_v;
            r_s2_last <= r_s1_last;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_z    <= r_s1_z;
        end
    end

    // Products rounded half away from zero on the magnitude.
    logic [PROD_W-1:0]   prod_c;
    logic [PROD_W-1:0]   prod_s;
    logic [RADIUS_W-1:0] n_s3_mc;
    logic [RADIUS_W-1:0] n_s3_ms;

    always_comb begin
        prod_c  = PROD_W'(r_radius) * PROD_W'(r_s2_cos) + PROD_W'(16384);
        prod_s  = PROD_W'(r_radius) * PROD_W'(r_s2_sin) + PROD_W'(16384);
        n_s3_mc = prod_c[PROD_W-1:TRIG_W];
        n_s3_ms = prod_s[PROD_W-1:TRIG_W];
    end

    // Stage 3: offsets registered, add and saturate.
    logic                r_s3_vld;
    logic [RADIUS_W-1:0] r_s3_mc;
    logic [RADIUS_W-1:0] r_s3_ms;
    logic                r_s3_neg;
    logic [1:0]          r_s3_v;
    logic                r_s3_last;
    logic [COORD_W-1:0]  r_s3_x;
    logic [COORD_W-1:0]  r_s3_y;
    logic [COORD_W-1:0]  r_s3_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_mc   <= n_s3_mc;
            r_s3_ms   <= n_s3_ms;
            r_s3_neg  <= r_s2_neg;
            r_s3_v    <= r_s2_v;
            r_s3_last <= r_s2_last;
            r_s3_x    <= r_s2_x;
            r_s3_y    <= r_s2_y;
            r_s3_z    <= r_s2_z;
        end
    end

    logic                      right;
    logic                      bottom;
    logic signed [COORD_W:0]   dc;
    logic signed [COORD_W:0]   ds;
    logic signed [COORD_W+1:0] bx_w;
    logic signed [COORD_W+1:0] by_w;
    logic signed [COORD_W+1:0] bz_w;
    logic signed [COORD_W+1:0] sum_x;
    logic signed [COORD_W+1:0] sum_y;
    logic signed [COORD_W+1:0] sum_z;
    logic [COORD_W-1:0]        n_out_x;
    logic [COORD_W-1:0]        n_out_y;
    logic [COORD_W-1:0]        n_out_z;
    logic [COORD_W-1:0]        n_out_u;

    always_comb begin
        right  = r_s3_v[0];
        bottom = r_s3_v[1];
        dc     = $signed({2'b00, r_s3_mc});
        if (r_s3_neg) begin
            dc = -$signed({2'b00, r_s3_mc});
        end
        ds     = $signed({2'b00, r_s3_ms});
        bx_w   = $signed({{2{r_s3_x[COORD_W-1]}}, r_s3_x});
        by_w   = $signed({{2{r_s3_y[COORD_W-1]}}, r_s3_y});
        bz_w   = $signed({{2{r_s3_z[COORD_W-1]}}, r_s3_z});
        sum_x  = right ? (bx_w + {dc[COORD_W], dc}) : (bx_w - {dc[COORD_W], dc});
        sum_z  = right ? (bz_w + {ds[COORD_W], ds}) : (bz_w - {ds[COORD_W], ds});
        sum_y  = bottom ? by_w
                        : (by_w + $signed({{2{r_height[COORD_W-1]}}, r_height}));
        n_out_x = sat34(sum_x);
        n_out_y = sat34(sum_y);
        n_out_z = sat34(sum_z);
        n_out_u = right ? r_tex_right : r_tex_left;
    end

    // Stage 4: output register.
    logic               r_out_vld;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [COORD_W-1:0] r_out_z;
    logic [COORD_W-1:0] r_out_u;
    logic               r_out_bottom;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x      <= n_out_x;
            r_out_y      <= n_out_y;
            r_out_z      <= n_out_z;
            r_out_u      <= n_out_u;
            r_out_bottom <= bottom;
            r_out_last   <= r_s3_last;
        end
    end

    assign o_vout.valid        = r_out_vld;
    assign o_vout.vert_x       = r_out_x;
    assign o_vout.vert_y       = r_out_y;
    assign o_vout.vert_z       = r_out_z;
    assign o_vout.tex_u        = r_out_u;
    assign o_vout.tex_v_bottom = r_out_bottom;
    assign o_vout.last_vertex  = r_out_last;

endmodule

// ----- sim/tb_crossed_quad_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// tb_crossed_quad_vertex_generator: self-checking bench of the vertex generator
// Base positions are fed through the input channel under random gaps. Every
// vertex word is checked against a local model that expands each accepted
// position into its rotated quads, using its own cosine and sine table.
// ----------------------------------------------------------------------------
module tb_crossed_quad_vertex_generator import cqv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CORNERS     = 4;
    localparam int  HOLD_CYCLES = 200;
    localparam int  STALL_LIMIT = 2000;
    localparam int  FLUSH_WAIT  = 8;
    localparam real PI_VALUE    = 3.14159265358979323846;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_base;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] u;
        logic               bottom;
        logic               last;
    } t_vertex;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  src_valid = 1'b0;
    t_base                 src_base  = '0;
    logic                  snk_ready = 1'b0;
    logic                  in_taken  = 1'b0;

    // Bench copy of the configuration, starting at the reset values.
    logic [RADIUS_W-1:0] cfg_radius = RADIUS_W'(65536);
    logic [COORD_W-1:0]  cfg_height = 32'h0001_0000;
    logic [DIVREG_W-1:0] cfg_divs   = DIVREG_W'(1);
    logic [COORD_W-1:0]  cfg_tex_l  = 32'h0000_0000;
    logic [COORD_W-1:0]  cfg_tex_r  = 32'h0001_0000;

    int trig_cos [MAX_DIVISIONS][MAX_DIVISIONS];
    int trig_sin [MAX_DIVISIONS][MAX_DIVISIONS];

    t_base   pending_bases[$];
    t_vertex expected_vertices[$];

    int   fail_count   = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    logic calm         = 1'b0;

    cqv_in_if  vin ();
    cqv_out_if vout ();

    assign vin.valid  = src_valid;
    assign vin.base_x = src_base.x;
    assign vin.base_y = src_base.y;
    assign vin.base_z = src_base.z;
    assign vout.ready = snk_ready;

    crossed_quad_vertex_generator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vin      (vin),
        .o_vout     (vout)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int to_q15(real v);
        real m;
        int  q;
        m = (v < 0.0) ? -v : v;
        q = $rtoi($floor(m * 32768.0 + 0.5));
        if (q > 32767) q = 32767;
        return (v < 0.0) ? -q : q;
    endfunction

    // Magnitude of radius*c/2^15 is rounded half away from zero.
    function automatic longint scale_radius(logic [RADIUS_W-1:0] r, int c);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = (longint'(r) * mag + 16384) >>> 15;
        return (c < 0) ? -q : q;
    endfunction

    function automatic logic [COORD_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[COORD_W-1:0];
    endfunction

    task automatic expand_base(input t_base pos);
        longint  bx, by, bz, hgt, dc, ds;
        int      nq, k, corner;
        logic    right, bottom;
        t_vertex v;
        bx  = longint'($signed(pos.x));
        by  = longint'($signed(pos.y));
        bz  = longint'($signed(pos.z));
        hgt = longint'($signed(cfg_height));
        if (cfg_divs == 0) nq = 1;
        else if (cfg_divs > MAX_DIVISIONS) nq = MAX_DIVISIONS;
        else nq = int'(cfg_divs);
        for (k = 0; k < nq; k++) begin
            dc = scale_radius(cfg_radius, trig_cos[nq-1][k]);
            ds = scale_radius(cfg_radius, trig_sin[nq-1][k]);
            // Corners run top-left, top-right, bottom-left, bottom-right.
            for (corner = 0; corner < CORNERS; corner++) begin
                right    = corner[0];
                bottom   = corner[1];
                v.x      = clip32(right ? bx + dc : bx - dc);
                v.y      = clip32(bottom ? by : by + hgt);
                v.z      = clip32(right ? bz + ds : bz - ds);
                v.u      = right ? cfg_tex_r : cfg_tex_l;
                v.bottom = bottom;
                v.last   = (k == nq - 1) && (corner == CORNERS - 1);
                expected_vertices.push_back(v);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_RADIUS:    cfg_radius = data[RADIUS_W-1:0];
            CFG_HEIGHT:    cfg_height = data;
            CFG_DIVISIONS: cfg_divs   = data[DIVREG_W-1:0];
            CFG_TEX_LEFT:  cfg_tex_l  = data;
            CFG_TEX_RIGHT: cfg_tex_r  = data;
            default: ;
        endcase
    endtask

    // Writes all registers, then pokes an unmapped index that must be ignored.
    task automatic apply_settings(input logic [31:0] radius, input logic [31:0] height,
                                  input logic [31:0] divs, input logic [31:0] tl,
                                  input logic [31:0] tr);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(CFG_TEX_RIGHT + 1, (1 << CFG_IDX_W) - 1));
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_HEIGHT, height);
        write_reg(CFG_DIVISIONS, divs);
        write_reg(CFG_TEX_LEFT, tl);
        write_reg(CFG_TEX_RIGHT, tr);
        write_reg(spare, $urandom);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bases.size() != 0 || src_valid || expected_vertices.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
            2:       return 32'h8000_0000 + $urandom_range(0, 1 << 20);
            default: return $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
    endfunction

    function automatic logic [31:0] rand_radius();
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return $urandom_range(0, 1 << 20);
            default: return 32'h7FFF_FFFF - $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [31:0] rand_height();
        if ($urandom_range(1)) return $urandom;
        return $urandom_range(0, 1 << 18) - (1 << 17);
    endfunction

    // Sender: holds a word until it is taken, then may pause before the next.
    always @(negedge i_clk) begin
        if (!src_valid || in_taken) begin
            if (pending_bases.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
                src_valid <= 1'b1;
                src_base  <= pending_bases.pop_front();
            end else begin
                src_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_taken <= src_valid && vin.ready;
        if (src_valid && vin.ready) expand_base(src_base);
    end

    // Receiver: random stalls, plus one long hold-off so the pipe backs up.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            snk_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            snk_ready <= 1'b0;
        end else begin
            snk_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge i_clk) begin : vertex_check
        t_vertex got;
        t_vertex want;
        if (vout.valid && vout.ready) begin
            got = '{vout.vert_x, vout.vert_y, vout.vert_z, vout.tex_u,
                    vout.tex_v_bottom, vout.last_vertex};
            if (expected_vertices.size() == 0) begin
                $display("%0t: unexpected vertex word %h %h %h %h %b %b", $time,
                         got.x, got.y, got.z, got.u, got.bottom, got.last);
                fail_count++;
            end else begin
                want = expected_vertices.pop_front();
                if (got !== want) begin
                    $display("%0t: vertex mismatch, expected %h %h %h %h %b %b, actual %h %h %h %h %b %b",
                             $time, want.x, want.y, want.z, want.u, want.bottom, want.last,
                             got.x, got.y, got.z, got.u, got.bottom, got.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          n, k, nq;
        logic [31:0] div_code;
        for (n = 1; n <= MAX_DIVISIONS; n++) begin
            for (k = 0; k < MAX_DIVISIONS; k++) begin
                trig_cos[n-1][k] = (k < n) ? to_q15($cos(k * PI_VALUE / n)) : 0;
                trig_sin[n-1][k] = (k < n) ? to_q15($sin(k * PI_VALUE / n)) : 0;
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: one quad of unit radius and height.
        pending_bases.push_back('{32'h0, 32'h0, 32'h0});
        pending_bases.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_bases.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        drain();

        // Largest radius and height, sixteen quads: saturation both ways.
        apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, MAX_DIVISIONS,
                       32'h8000_0000, 32'h7FFF_FFFF);
        pending_bases.push_back('{32'h0, 32'h0, 32'h0});
        pending_bases.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_bases.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        drain();

        // Zero radius, most negative height, and a zero division count.
        apply_settings(32'h0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        pending_bases.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_bases.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_bases.push_back('{32'h0, 32'h0, 32'h0});
        drain();

        // Division count above the maximum, radius with the unused top bit set.
        apply_settings(32'hC000_0000, 32'hFFFF_FFFF, (1 << DIVREG_W) - 1,
                       32'h0, 32'hFFFF_FFFF);
        repeat (3) pending_bases.push_back('{rand_coord(), rand_coord(), rand_coord()});
        drain();

        apply_settings(32'h7FFF_0000, 32'h0, 2, $urandom, $urandom);
        pending_bases.push_back('{32'h7FFF_FFFF, 32'h0, 32'h8000_0000});
        pending_bases.push_back('{32'h8000_0000, 32'h0, 32'h7FFF_FFFF});
        drain();

        for (nq = 1; nq <= MAX_DIVISIONS; nq++) begin
            div_code = nq;
            if (nq == 1 && $urandom_range(1)) div_code = 0;
            if (nq == MAX_DIVISIONS && $urandom_range(1))
                div_code = $urandom_range(MAX_DIVISIONS + 1, (1 << DIVREG_W) - 1);
            calm = (nq == 5);
            apply_settings(rand_radius(), rand_height(), div_code, $urandom, $urandom);
            // Short runs per word let the sender pile up behind the hold-off.
            if (nq == 1) hold_req = 1'b1;
            repeat (9) pending_bases.push_back('{rand_coord(), rand_coord(), rand_coord()});
            drain();
        end
        calm = 1'b0;

        repeat (FLUSH_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cqv_pkg.sv
rtl/core/cqv_in_if.sv
rtl/core/cqv_out_if.sv
rtl/core/crossed_quad_vertex_generator.sv
sim/tb_crossed_quad_vertex_generator.sv
